/* src/bts_pkg.sv */
`default_nettype none
package bts_pkg;

    localparam int TIME_WIDTH_DEF = 24;
    localparam int HALF_WIDTH_DEF = 16;
    localparam int OP_W = 2;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int PHASE_W = 2;
    localparam int HALF_RESET = 125;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_HIGH  = 2'd2;
    localparam logic [OP_W-1:0] OP_LOW   = 2'd3;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HIGH  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LOW   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_PAUSE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_IDX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_IDX  = 1'd1;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic run_done;
    } t_result;

endpackage
`default_nettype wire

/* src/bts_if.sv */
`default_nettype none
interface bts_in_if #(
    parameter int TIME_WIDTH = bts_pkg::TIME_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [bts_pkg::OP_W-1:0]     operation;
    logic [bts_pkg::COUNT_W-1:0]  beep_count;
    logic [TIME_WIDTH-1:0]        beep_us;
    logic [TIME_WIDTH-1:0]        pause_us;

    modport source (output valid, operation, beep_count, beep_us, pause_us, input ready);
    modport sink (input valid, operation, beep_count, beep_us, pause_us, output ready);
endinterface

interface bts_out_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic run_done;

    modport source (output valid, pin_level, busy_res, run_done, input ready);
    modport sink (input valid, pin_level, busy_res, run_done, output ready);
endinterface
`default_nettype wire

/* src/bts_cfg_regs.sv */
`default_nettype none
module bts_cfg_regs #(
    parameter int HALF_PERIOD_WIDTH = bts_pkg::HALF_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [HALF_PERIOD_WIDTH-1:0]    i_cfg_data,
    output logic      [HALF_PERIOD_WIDTH-1:0]    o_high_ticks,
    output logic      [HALF_PERIOD_WIDTH-1:0]    o_low_ticks
);
    import bts_pkg::*;

    logic [HALF_PERIOD_WIDTH-1:0] r_high;
    logic [HALF_PERIOD_WIDTH-1:0] r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= HALF_PERIOD_WIDTH'(HALF_RESET);
            r_low  <= HALF_PERIOD_WIDTH'(HALF_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HIGH_IDX: r_high <= i_cfg_data;
                CFG_LOW_IDX:  r_low  <= i_cfg_data;
            endcase
        end
    end

    assign o_high_ticks = r_high;
    assign o_low_ticks  = r_low;
endmodule
`default_nettype wire

/* src/bts_tone_core.sv */
`default_nettype none
module bts_tone_core #(
    parameter int TIME_WIDTH        = bts_pkg::TIME_WIDTH_DEF,
    parameter int HALF_PERIOD_WIDTH = bts_pkg::HALF_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [bts_pkg::OP_W-1:0]      i_operation,
    input  wire logic [bts_pkg::COUNT_W-1:0]   i_beep_count,
    input  wire logic [TIME_WIDTH-1:0]         i_beep_us,
    input  wire logic [TIME_WIDTH-1:0]         i_pause_us,
    input  wire logic [HALF_PERIOD_WIDTH-1:0]  i_high_ticks,
    input  wire logic [HALF_PERIOD_WIDTH-1:0]  i_low_ticks,
    output bts_pkg::t_result                   o_result
);
    import bts_pkg::*;

    localparam int CNT_W = (TIME_WIDTH > HALF_PERIOD_WIDTH) ? TIME_WIDTH : HALF_PERIOD_WIDTH;
    localparam int PER_W = HALF_PERIOD_WIDTH + 1;
    localparam int CMP_W = (TIME_WIDTH > PER_W) ? TIME_WIDTH : PER_W;

    logic [PHASE_W-1:0]    r_phase,  n_phase;
    logic [CNT_W-1:0]      r_cnt,    n_cnt;
    logic [TIME_WIDTH-1:0] r_time,   n_time;
    logic [COUNT_W-1:0]    r_beeps,  n_beeps;
    logic [TIME_WIDTH-1:0] r_sbeep,  n_sbeep;
    logic [TIME_WIDTH-1:0] r_spause, n_spause;
    logic                  r_pin,    n_pin;
    logic                  n_done;

    logic [HALF_PERIOD_WIDTH-1:0] eff_high;
    logic [HALF_PERIOD_WIDTH-1:0] eff_low;
    logic [PER_W-1:0]             period;
    logic [CMP_W-1:0]             period_x;
    logic [CNT_W-1:0]             cnt_dec;

    logic [TIME_WIDTH-1:0]        s_t_in;
    logic [TIME_WIDTH-1:0]        s_sbeep_in;
    logic [TIME_WIDTH-1:0]        s_pause_in;
    logic [COUNT_W-1:0]           s_beeps_in;
    logic                         fit_t;
    logic                         fit_s;
    logic [PHASE_W-1:0]           s_phase;
    logic [CNT_W-1:0]             s_cnt;
    logic [TIME_WIDTH-1:0]        s_time;
    logic [COUNT_W-1:0]           s_beeps;
    logic                         s_pin;
    logic                         s_done;

    assign eff_high = (i_high_ticks != '0) ? i_high_ticks : HALF_PERIOD_WIDTH'(1);
    assign eff_low  = (i_low_ticks  != '0) ? i_low_ticks  : HALF_PERIOD_WIDTH'(1);
    assign period   = PER_W'(eff_high) + PER_W'(eff_low);
    assign period_x = CMP_W'(period);
    assign cnt_dec  = (r_cnt != '0) ? r_cnt - CNT_W'(1) : '0;

    always_comb begin
        if (i_operation == OP_START) begin
            s_t_in     = i_beep_us;
            s_sbeep_in = i_beep_us;
            s_pause_in = i_pause_us;
            s_beeps_in = i_beep_count;
        end else begin
            s_t_in     = (r_phase == PH_PAUSE) ? r_sbeep : r_time;
            s_sbeep_in = r_sbeep;
            s_pause_in = r_spause;
            s_beeps_in = r_beeps;
        end
    end

    assign fit_t = CMP_W'(s_t_in) >= period_x;
    assign fit_s = CMP_W'(s_sbeep_in) >= period_x;

    // next period or beep end; skips beeps too short for one period
    always_comb begin
        s_phase = PH_IDLE;
        s_cnt   = '0;
        s_time  = '0;
        s_beeps = '0;
        s_pin   = 1'b0;
        s_done  = 1'b0;
        if (fit_t) begin
            s_phase = PH_HIGH;
            s_cnt   = CNT_W'(eff_high);
            s_time  = TIME_WIDTH'(CMP_W'(s_t_in) - period_x);
            s_beeps = s_beeps_in;
            s_pin   = 1'b1;
        end else if (s_beeps_in == COUNT_W'(1)) begin
            s_done  = 1'b1;
        end else if (s_pause_in != '0) begin
            s_phase = PH_PAUSE;
            s_cnt   = CNT_W'(s_pause_in);
            s_time  = s_t_in;
            s_beeps = s_beeps_in - COUNT_W'(1);
        end else if (fit_s) begin
            s_phase = PH_HIGH;
            s_cnt   = CNT_W'(eff_high);
            s_time  = TIME_WIDTH'(CMP_W'(s_sbeep_in) - period_x);
            s_beeps = s_beeps_in - COUNT_W'(1);
            s_pin   = 1'b1;
        end else begin
            s_done  = 1'b1;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_time   = r_time;
        n_beeps  = r_beeps;
        n_sbeep  = r_sbeep;
        n_spause = r_spause;
        n_pin    = r_pin;
        n_done   = 1'b0;
        unique case (i_operation)
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (cnt_dec != '0) begin
                        n_cnt = cnt_dec;
                    end else if (r_phase == PH_HIGH) begin
                        n_phase = PH_LOW;
                        n_cnt   = CNT_W'(eff_low);
                        n_pin   = 1'b0;
                    end else begin
                        n_phase = s_phase;
                        n_cnt   = s_cnt;
                        n_time  = s_time;
                        n_beeps = s_beeps;
                        n_pin   = s_pin;
                        n_done  = s_done;
                    end
                end
            end
            OP_START: begin
                if (i_beep_count != '0) begin
                    n_sbeep  = i_beep_us;
                    n_spause = i_pause_us;
                    n_phase  = s_phase;
                    n_cnt    = s_cnt;
                    n_time   = s_time;
                    n_beeps  = s_beeps;
                    n_pin    = s_pin;
                    n_done   = s_done;
                end
            end
            OP_HIGH, OP_LOW: begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
                n_time  = '0;
                n_beeps = '0;
                n_pin   = (i_operation == OP_HIGH);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_time   <= '0;
            r_beeps  <= '0;
            r_sbeep  <= '0;
            r_spause <= '0;
            r_pin    <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_time   <= n_time;
            r_beeps  <= n_beeps;
            r_sbeep  <= n_sbeep;
            r_spause <= n_spause;
            r_pin    <= n_pin;
        end
    end

    assign o_result.pin_level = n_pin;
    assign o_result.busy_res  = (n_phase != PH_IDLE);
    assign o_result.run_done  = n_done;

    a_busy_has_beeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_beeps != '0))
        else $error("active run with no beeps left");
    a_busy_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_cnt != '0))
        else $error("active phase with empty counter");
    a_pin_follows_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_pin == (r_phase == PH_HIGH)))
        else $error("pin level disagrees with tone phase");
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && n_done) |=> (r_phase == PH_IDLE && r_beeps == '0))
        else $error("run finished but state not idle");
endmodule
`default_nettype wire

/* src/bts_result_reg.sv */
`default_nettype none
module bts_result_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire bts_pkg::t_result  i_result,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output bts_pkg::t_result       o_result
);
    import bts_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule
`default_nettype wire

/* src/beep_tone_sequencer_top.sv */
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    operation, beep_count, beep_us, pause_us
//  o_out     out  valid/ready    pin_level, busy_res, run_done
//  cfg       in   i_cfg_we       i_cfg_index, i_cfg_data (0 high_ticks, 1 low_ticks)
//
//  One item per cycle while i_in.ready is high; its result sits in the output register from the next cycle.
//  The state update for an item is one pass of logic set by a 24-bit compare/subtract.
//  Reset clears the run state and loads 125 into both half-period registers.
//  A stalled output holds i_in.ready low only while the output register is full.
`default_nettype none
module beep_tone_sequencer_top #(
    parameter int TIME_WIDTH        = bts_pkg::TIME_WIDTH_DEF,
    parameter int HALF_PERIOD_WIDTH = bts_pkg::HALF_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    bts_in_if.sink                               i_in,
    bts_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [HALF_PERIOD_WIDTH-1:0]    i_cfg_data
);
    import bts_pkg::*;

    logic [HALF_PERIOD_WIDTH-1:0] high_ticks;
    logic [HALF_PERIOD_WIDTH-1:0] low_ticks;
    logic                         in_ready;
    logic                         accept;
    t_result                      core_result;
    t_result                      out_result;

    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    bts_cfg_regs #(
        .HALF_PERIOD_WIDTH(HALF_PERIOD_WIDTH)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_high_ticks (high_ticks),
        .o_low_ticks  (low_ticks)
    );

    bts_tone_core #(
        .TIME_WIDTH        (TIME_WIDTH),
        .HALF_PERIOD_WIDTH (HALF_PERIOD_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_in.operation),
        .i_beep_count (i_in.beep_count),
        .i_beep_us    (i_in.beep_us),
        .i_pause_us   (i_in.pause_us),
        .i_high_ticks (high_ticks),
        .i_low_ticks  (low_ticks),
        .o_result     (core_result)
    );

    bts_result_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (in_ready),
        .i_result (core_result),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (out_result)
    );

    assign o_out.pin_level = out_result.pin_level;
    assign o_out.busy_res  = out_result.busy_res;
    assign o_out.run_done  = out_result.run_done;
endmodule
`default_nettype wire

/* bench/beep_tone_sequencer_top_tb.sv */
`timescale 1ns / 1ps
module beep_tone_sequencer_top_tb;
    import bts_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;
    localparam int HW = HALF_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1650;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HW-1:0] cfg_data;

    bts_in_if #(.TIME_WIDTH(TW)) in_if ();
    bts_out_if out_if ();

    beep_tone_sequencer_top #(
        .TIME_WIDTH(TW),
        .HALF_PERIOD_WIDTH(HW)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_if),
        .o_out(out_if),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tone state tracked alongside the block
    logic [HW-1:0]      cfg_high = HW'(HALF_RESET);
    logic [HW-1:0]      cfg_low = HW'(HALF_RESET);
    logic [PHASE_W-1:0] tone_phase = PH_IDLE;
    logic [TW-1:0]      phase_left = '0;
    logic [TW-1:0]      beep_left = '0;
    logic [COUNT_W-1:0] beeps_to_go = '0;
    logic [TW-1:0]      run_beep_us = '0;
    logic [TW-1:0]      run_pause_us = '0;
    logic               pin_now = 1'b0;

    t_result tone_expected[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned stuck_cycles = 0;
    int unsigned send_gap_max = 10;
    int unsigned recv_gap_max = 10;
    int unsigned hold_request = 0;

    function automatic int unsigned half_or_one(logic [HW-1:0] half);
        return (half == '0) ? 1 : int'(half);
    endfunction

    // start the next period, or close the beep and move on; 1 when the run ends
    function automatic logic next_period();
        int unsigned period;
        logic settled;
        logic finished;
        period = half_or_one(cfg_high) + half_or_one(cfg_low);
        settled = 1'b0;
        finished = 1'b0;
        while (!settled) begin
            if (beep_left >= period) begin
                beep_left = TW'(beep_left - period);
                tone_phase = PH_HIGH;
                phase_left = TW'(half_or_one(cfg_high));
                pin_now = 1'b1;
                settled = 1'b1;
            end else begin
                beeps_to_go = beeps_to_go - 1'b1;
                pin_now = 1'b0;
                if (beeps_to_go == '0) begin
                    tone_phase = PH_IDLE;
                    phase_left = '0;
                    beep_left = '0;
                    finished = 1'b1;
                    settled = 1'b1;
                end else if (run_pause_us != '0) begin
                    tone_phase = PH_PAUSE;
                    phase_left = run_pause_us;
                    settled = 1'b1;
                end else begin
                    beep_left = run_beep_us;
                end
            end
        end
        return finished;
    endfunction

    function automatic t_result tone_step(logic [OP_W-1:0] op, logic [COUNT_W-1:0] count,
                                          logic [TW-1:0] beep, logic [TW-1:0] pause);
        logic finished;
        t_result r;
        finished = 1'b0;
        case (op)
            OP_TICK: begin
                if (tone_phase != PH_IDLE) begin
                    if (phase_left != '0) phase_left = phase_left - 1'b1;
                    if (phase_left == '0) begin
                        case (tone_phase)
                            PH_HIGH: begin
                                tone_phase = PH_LOW;
                                phase_left = TW'(half_or_one(cfg_low));
                                pin_now = 1'b0;
                            end
                            PH_LOW: begin
                                finished = next_period();
                            end
                            default: begin
                                beep_left = run_beep_us;
                                finished = next_period();
                            end
                        endcase
                    end
                end
            end
            OP_START: begin
                if (count != '0) begin
                    run_beep_us = beep;
                    run_pause_us = pause;
                    beeps_to_go = count;
                    beep_left = beep;
                    finished = next_period();
                end
            end
            default: begin
                tone_phase = PH_IDLE;
                phase_left = '0;
                beep_left = '0;
                beeps_to_go = '0;
                pin_now = (op == OP_HIGH);
            end
        endcase
        r.pin_level = pin_now;
        r.busy_res = (tone_phase != PH_IDLE);
        r.run_done = finished;
        return r;
    endfunction

    task automatic report_result_error(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d %s: expected pin %0b busy %0b done %0b, got pin %0b busy %0b done %0b",
                     results_seen, what, want.pin_level, want.busy_res, want.run_done,
                     got.pin_level, got.busy_res, got.run_done);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        logic moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_if.valid && in_if.ready) begin
                tone_expected.push_back(tone_step(in_if.operation, in_if.beep_count,
                                                  in_if.beep_us, in_if.pause_us));
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                got.pin_level = out_if.pin_level;
                got.busy_res = out_if.busy_res;
                got.run_done = out_if.run_done;
                results_seen++;
                moved = 1'b1;
                if (tone_expected.size() == 0) begin
                    report_result_error("unexpected", '0, got);
                end else begin
                    want = tone_expected.pop_front();
                    if (got != want) report_result_error("mismatch", want, got);
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int unsigned stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) recv_gap_max = (recv_gap_max != 0) ? 0 : 10;
            if (hold_request != 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = $urandom_range(0, recv_gap_max);
            end
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    task automatic offer_item(logic [OP_W-1:0] op, logic [COUNT_W-1:0] count,
                              logic [TW-1:0] beep, logic [TW-1:0] pause);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.operation <= op;
        in_if.beep_count <= count;
        in_if.beep_us <= beep;
        in_if.pause_us <= pause;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic offer_ticks(int unsigned n);
        repeat (n) offer_item(OP_TICK, COUNT_W'($urandom()), TW'($urandom()), TW'($urandom()));
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tone_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_half_periods(logic [HW-1:0] high_us, logic [HW-1:0] low_us);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= CFG_HIGH_IDX;
        cfg_data <= high_us;
        @(posedge i_clk);
        cfg_high = high_us;
        cfg_index <= CFG_LOW_IDX;
        cfg_data <= low_us;
        @(posedge i_clk);
        cfg_low = low_us;
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed_cases();
        offer_item(OP_TICK, '1, '1, '1);
        offer_item(OP_START, '0, '1, '1);
        offer_item(OP_HIGH, '0, '0, '0);
        offer_item(OP_TICK, '0, '0, '0);
        offer_item(OP_START, 8'd1, '1, '1);
        offer_item(OP_TICK, '0, '0, '0);
        offer_item(OP_START, 8'd3, TW'(10), '1);
        offer_item(OP_TICK, '0, '0, '0);
        offer_item(OP_LOW, '1, '1, '1);
        offer_item(OP_START, '1, '0, '0);
        offer_item(OP_START, 8'd2, TW'(250), '0);
        offer_item(OP_HIGH, '1, '0, '1);
        offer_item(OP_LOW, '0, '1, '0);
        set_half_periods('0, '0);
        offer_item(OP_START, 8'd2, TW'(2), '0);
        offer_ticks(4);
        offer_item(OP_START, 8'd2, TW'(3), TW'(1));
        offer_ticks(6);
    endtask

    task automatic sweep_half_period_extremes();
        set_half_periods('1, '1);
        offer_item(OP_START, 8'd2, '1, TW'(5));
        offer_ticks(3);
        offer_item(OP_HIGH, '0, '0, '0);
        set_half_periods(HW'(1), '1);
        offer_item(OP_START, 8'd1, TW'(65536), '0);
        offer_ticks(3);
        offer_item(OP_LOW, '0, '0, '0);
        set_half_periods('1, HW'(1));
        offer_item(OP_START, 8'd3, TW'(100), '0);
        set_half_periods(HW'(1), HW'(1));
        offer_item(OP_START, 8'd1, TW'(2), '0);
        offer_ticks(2);
    endtask

    task automatic stall_output_stretch();
        set_half_periods(HW'(2), HW'(3));
        send_gap_max = 0;
        hold_request = LONG_HOLD;
        offer_item(OP_START, 8'd3, TW'(20), TW'(4));
        offer_ticks(60);
        send_gap_max = 10;
        drain_results();
    endtask

    task automatic play_one_run(inout int unsigned useful);
        logic [COUNT_W-1:0] count;
        logic [TW-1:0] beep;
        logic [TW-1:0] pause;
        int unsigned ticks;
        int unsigned n;
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) offer_item(OP_W'($urandom()), COUNT_W'($urandom()),
                                  TW'($urandom()), TW'($urandom()));
            useful += n;
            return;
        end
        if ($urandom_range(0, 7) == 0) begin
            count = COUNT_W'($urandom_range(1, 255));
            beep = TW'($urandom_range(0, 1));
            pause = '0;
        end else begin
            count = COUNT_W'($urandom_range(1, 4));
            beep = TW'($urandom_range(0, 40));
            pause = ($urandom_range(0, 2) == 0) ? '0 : TW'($urandom_range(1, 12));
        end
        offer_item(OP_START, count, beep, pause);
        ticks = count * (beep + pause) + $urandom_range(0, 2);
        if ($urandom_range(0, 5) == 0) begin
            ticks = $urandom_range(0, ticks);
            offer_ticks(ticks);
            if ($urandom_range(0, 2) != 0) begin
                offer_item(($urandom_range(0, 1) != 0) ? OP_HIGH : OP_LOW,
                           COUNT_W'($urandom()), TW'($urandom()), TW'($urandom()));
                useful++;
            end
        end else begin
            offer_ticks(ticks);
        end
        useful += 1 + ticks;
    endtask

    task automatic run_random_sequences();
        int unsigned useful;
        int unsigned budget;
        logic [HW-1:0] high_us;
        logic [HW-1:0] low_us;
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: begin
                    high_us = '0;
                    low_us = HW'($urandom_range(1, 4));
                end
                1: begin
                    high_us = HW'($urandom_range(1, 8));
                    low_us = HW'($urandom());
                end
                2: begin
                    high_us = HW'(1);
                    low_us = HW'(1);
                end
                default: begin
                    high_us = HW'($urandom_range(1, 6));
                    low_us = HW'($urandom_range(1, 6));
                end
            endcase
            set_half_periods(high_us, low_us);
            budget = useful + 250;
            while (useful < budget && useful < RANDOM_ITEMS) play_one_run(useful);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.operation = OP_TICK;
        in_if.beep_count = '0;
        in_if.beep_us = '0;
        in_if.pause_us = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_HIGH_IDX;
        cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed_cases();
        sweep_half_period_extremes();
        stall_output_stretch();
        run_random_sequences();
        drain_results();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

/* files.f */
src/bts_pkg.sv
src/bts_if.sv
src/bts_cfg_regs.sv
src/bts_tone_core.sv
src/bts_result_reg.sv
src/beep_tone_sequencer_top.sv
bench/beep_tone_sequencer_top_tb.sv
